[hw/rtl/sbsk_pkg.sv]
// Shared constants and types for the stable bucket sort block.
`timescale 1ns / 1ps
package sbsk_pkg;

  localparam int unsigned SLOTS_DEF       = 32;
  localparam int unsigned TYPE_COUNT_DEF  = 8;
  localparam int unsigned GRADE_COUNT_DEF = 8;

  // Type keys start above zero; type zero is never grouped.
  localparam int unsigned TYPE_FIRST_KEY = 1;

  localparam int unsigned KEY_W  = 5;
  localparam int unsigned MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_BY_TYPE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BY_GRADE = 2'd1;

  typedef struct packed {
    logic [31:0] payload;
    logic [3:0]  grade_key;
    logic [3:0]  type_key;
    logic        has_data;
    logic        occupied;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

[hw/rtl/sbsk_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module sbsk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/stable_bucket_sort_by_key_core.sv]
// Stable bucket sort of a slot list by type or grade key, top level.
//
// Slots stream in one per cycle while the block is loading and are written to
// an internal RAM of SLOTS entries; slots beyond SLOTS are dropped. The item
// carrying tlast ends the list and starts the sort: the block sweeps the
// stored slots once for every key in range (type keys 1 to TYPE_COUNT-1, or
// grade keys 0 to GRADE_COUNT-1, chosen by the sort mode register), reading
// each stored slot in ST_SCAN_RD and checking it for a match in ST_SCAN_EV,
// since the RAM read port is registered. Matching slots go out in key order,
// load order kept within a key, then empty padding items fill the list up to
// the loaded count at one per cycle while the output accepts them. In a mode
// that groups nothing the sweep is skipped and every result is padding;
// output back-pressure holds the sweep. No input is taken during the sort,
// and the next list may load while the final result still waits in the
// output register. The store needs no clearing after reset.
`timescale 1ns / 1ps
module stable_bucket_sort_by_key_core #(
  parameter int unsigned SLOTS       = sbsk_pkg::SLOTS_DEF,
  parameter int unsigned TYPE_COUNT  = sbsk_pkg::TYPE_COUNT_DEF,
  parameter int unsigned GRADE_COUNT = sbsk_pkg::GRADE_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [sbsk_pkg::MODE_W-1:0] cfg_wr_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // slot_occupied, has_data, type_key[3:0], grade_key[3:0], item_payload[31:0], pad
  input  logic [47:0]                 s_axis_tdata,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_occupied, out_payload[31:0], out_index[5:0], pad
  output logic [39:0]                 m_axis_tdata,
  output logic                        m_axis_tlast
);

  import sbsk_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_LOAD    = 2'd0;
  localparam logic [1:0] ST_SCAN_RD = 2'd1;
  localparam logic [1:0] ST_SCAN_EV = 2'd2;
  localparam logic [1:0] ST_PAD     = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [CW-1:0]     load_cnt_q, load_cnt_d;
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     scan_idx_q, scan_idx_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [KEY_W-1:0]  key_hi_q, key_hi_d;
  logic              by_grade_q, by_grade_d;

  logic              out_valid_q, out_valid_d;
  logic              out_occ_q, out_occ_d;
  logic [31:0]       out_payload_q, out_payload_d;
  logic [5:0]        out_index_q, out_index_d;
  logic              out_last_q, out_last_d;

  logic              in_acc;
  logic              out_free;
  logic              ram_we;
  logic              ram_re;
  slot_t             in_slot;
  slot_t             rd_slot;
  logic [SLOT_W-1:0] ram_rdata;
  logic [3:0]        rd_key;
  logic              rd_match;
  logic              scan_end;

  assign in_slot.occupied  = s_axis_tdata[0];
  assign in_slot.has_data  = s_axis_tdata[1];
  assign in_slot.type_key  = s_axis_tdata[5:2];
  assign in_slot.grade_key = s_axis_tdata[9:6];
  assign in_slot.payload   = s_axis_tdata[41:10];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Slots past the store size are dropped but still end the list on tlast.
  assign ram_we = in_acc && (load_cnt_q < CW'(SLOTS));
  assign ram_re = (state_q == ST_SCAN_RD);

  sbsk_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i (in_slot),
    .re_i    (ram_re),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_slot  = slot_t'(ram_rdata);
  assign rd_key   = by_grade_q ? rd_slot.grade_key : rd_slot.type_key;
  assign rd_match = rd_slot.occupied && rd_slot.has_data && ({1'b0, rd_key} == key_q);
  assign scan_end = (CW'(scan_idx_q) + CW'(1)) == n_q;

  always_comb begin
    state_d       = state_q;
    load_cnt_d    = load_cnt_q;
    n_d           = n_q;
    pos_d         = pos_q;
    scan_idx_d    = scan_idx_q;
    key_d         = key_q;
    key_hi_d      = key_hi_q;
    by_grade_d    = by_grade_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_occ_d     = out_occ_q;
    out_payload_d = out_payload_q;
    out_index_d   = out_index_q;
    out_last_d    = out_last_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (ram_we) begin
            load_cnt_d = load_cnt_q + CW'(1);
          end
          if (s_axis_tlast) begin
            n_d        = ram_we ? load_cnt_q + CW'(1) : load_cnt_q;
            load_cnt_d = '0;
            pos_d      = '0;
            scan_idx_d = '0;
            if (mode_q == MODE_BY_TYPE) begin
              key_d      = KEY_W'(TYPE_FIRST_KEY);
              key_hi_d   = KEY_W'(TYPE_COUNT);
              by_grade_d = 1'b0;
              state_d    = ST_SCAN_RD;
            end else if (mode_q == MODE_BY_GRADE) begin
              key_d      = '0;
              key_hi_d   = KEY_W'(GRADE_COUNT);
              by_grade_d = 1'b1;
              state_d    = ST_SCAN_RD;
            end else begin
              state_d = ST_PAD;
            end
          end
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        // Hold on a match until the output register frees up.
        if (!rd_match || out_free) begin
          if (rd_match) begin
            out_valid_d   = 1'b1;
            out_occ_d     = 1'b1;
            out_payload_d = rd_slot.payload;
            out_index_d   = 6'(pos_q);
            out_last_d    = (pos_q + CW'(1)) == n_q;
            pos_d         = pos_q + CW'(1);
          end
          if (scan_end) begin
            scan_idx_d = '0;
            if ((key_q + KEY_W'(1)) == key_hi_q) begin
              state_d = ST_PAD;
            end else begin
              key_d   = key_q + KEY_W'(1);
              state_d = ST_SCAN_RD;
            end
          end else begin
            scan_idx_d = scan_idx_q + AW'(1);
            state_d    = ST_SCAN_RD;
          end
        end
      end
      ST_PAD: begin
        if (pos_q == n_q) begin
          state_d = ST_LOAD;
        end else if (out_free) begin
          out_valid_d   = 1'b1;
          out_occ_d     = 1'b0;
          out_payload_d = '0;
          out_index_d   = 6'(pos_q);
          out_last_d    = (pos_q + CW'(1)) == n_q;
          pos_d         = pos_q + CW'(1);
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      mode_q      <= MODE_BY_TYPE;
      load_cnt_q  <= '0;
      n_q         <= '0;
      pos_q       <= '0;
      scan_idx_q  <= '0;
      key_q       <= '0;
      key_hi_q    <= '0;
      by_grade_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      n_q         <= n_d;
      pos_q       <= pos_d;
      scan_idx_q  <= scan_idx_d;
      key_q       <= key_d;
      key_hi_q    <= key_hi_d;
      by_grade_q  <= by_grade_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        mode_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_occ_q     <= out_occ_d;
    out_payload_q <= out_payload_d;
    out_index_q   <= out_index_d;
    out_last_q    <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_index_q, out_payload_q, out_occ_q};
  assign m_axis_tlast  = out_last_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= CW'(SLOTS))
    else $error("load count above store size");

  a_no_write_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_LOAD) && (load_cnt_q < CW'(SLOTS)))
    else $error("store written outside load or when full");

  a_scan_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_EV) |-> (CW'(scan_idx_q) < n_q) && (key_q < key_hi_q))
    else $error("scan outside loaded list or key range");

  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (pos_q <= n_q))
    else $error("more results than loaded slots");

endmodule

[verif/stable_bucket_sort_by_key_core_tb.sv]
// Self-checking testbench for the stable bucket sort core: directed table, then random lists.
`timescale 1ns / 1ps
module stable_bucket_sort_by_key_core_tb;
  import sbsk_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNSORTED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 52;
  localparam int unsigned PLAN_N = 22;

  typedef struct packed {
    logic        occupied;
    logic [31:0] payload;
    logic [5:0]  index;
    logic        last;
  } sorted_slot_t;

  typedef struct {
    bit          wr;
    bit [1:0]    mode;
    bit          occ;
    bit          data;
    bit [3:0]    ty;
    bit [3:0]    gr;
    bit [31:0]   pay;
    bit          last;
    bit          typed;
    bit          exp_occ;
    bit [31:0]   exp_pay;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [1:0]  cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic        no_gaps = 1'b0;
  int          fail_count = 0;
  int          idle_cycles = 0;

  // Predictor state: slots held for the open list and the current mode.
  slot_t        held_slots [SLOTS_DEF];
  int unsigned  held_n = 0;
  logic [1:0]   mode_shadow = MODE_BY_TYPE;
  sorted_slot_t pending_sorted [$];

  stim_row_t plan [PLAN_N] = '{
    // reset mode groups by type: lowest and highest type keys, all-ones and all-zeros payloads
    '{0, 0, 1, 1, 4'd1, 4'd0, 32'hFFFF_FFFF, 1, 1, 1, 32'hFFFF_FFFF},
    '{0, 0, 1, 1, 4'd7, 4'd15, 32'h0000_0000, 1, 1, 1, 32'h0000_0000},
    // type zero, type out of range, empty slot, slot without data: padding
    '{0, 0, 1, 1, 4'd0, 4'd3, 32'h1111_1111, 1, 1, 0, 32'h0},
    '{0, 0, 1, 1, 4'd15, 4'd3, 32'h2222_2222, 1, 1, 0, 32'h0},
    '{0, 0, 0, 1, 4'd3, 4'd3, 32'h3333_3333, 1, 1, 0, 32'h0},
    '{0, 0, 1, 0, 4'd3, 4'd3, 32'h4444_4444, 1, 1, 0, 32'h0},
    '{0, 0, 1, 1, 4'd7, 4'd1, 32'hA000_0001, 0, 0, 0, 32'h0},
    '{0, 0, 1, 1, 4'd3, 4'd2, 32'hA000_0002, 0, 0, 0, 32'h0},
    '{0, 0, 0, 1, 4'd3, 4'd2, 32'hA000_0003, 0, 0, 0, 32'h0},
    '{0, 0, 1, 1, 4'd1, 4'd5, 32'hA000_0004, 0, 0, 0, 32'h0},
    '{0, 0, 1, 1, 4'd3, 4'd6, 32'hA000_0005, 1, 0, 0, 32'h0},
    // grade mode: type zero no longer matters, grade 15 is out of range
    '{1, MODE_BY_GRADE, 1, 1, 4'd0, 4'd0, 32'h1234_5678, 1, 1, 1, 32'h1234_5678},
    '{0, 0, 1, 1, 4'd2, 4'd15, 32'h5555_5555, 1, 1, 0, 32'h0},
    '{0, 0, 1, 1, 4'd2, 4'd7, 32'h8765_4321, 1, 1, 1, 32'h8765_4321},
    '{0, 0, 1, 1, 4'd4, 4'd7, 32'hB000_0001, 0, 0, 0, 32'h0},
    '{0, 0, 1, 1, 4'd4, 4'd0, 32'hB000_0002, 0, 0, 0, 32'h0},
    '{0, 0, 1, 1, 4'd4, 4'd7, 32'hB000_0003, 0, 0, 0, 32'h0},
    '{0, 0, 1, 1, 4'd4, 4'd2, 32'hB000_0004, 1, 0, 0, 32'h0},
    // no grouping in the unsorted and reserved modes: every result is padding; then type mode again
    '{1, MODE_UNSORTED, 1, 1, 4'd1, 4'd1, 32'h6666_6666, 1, 1, 0, 32'h0},
    '{1, MODE_RESERVED, 1, 1, 4'd1, 4'd1, 32'h7777_7777, 1, 1, 0, 32'h0},
    '{1, MODE_BY_TYPE, 1, 1, 4'd5, 4'd1, 32'hC000_0001, 0, 0, 0, 32'h0},
    '{0, 0, 1, 1, 4'd2, 4'd1, 32'hC000_0002, 1, 0, 0, 32'h0}
  };

  logic [1:0] phase_mode [6] = '{MODE_BY_GRADE, MODE_BY_TYPE, MODE_UNSORTED,
                                 MODE_BY_TYPE, MODE_RESERVED, MODE_BY_GRADE};

  stable_bucket_sort_by_key_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (no_gaps || $urandom_range(0, 99) >= 26);
  end

  // Hold a slot; on the list end, emit the grouped list padded to its length.
  task automatic bucket_sort_slot(input slot_t s, input bit last);
    int unsigned key_lo;
    int unsigned key_hi;
    int unsigned pos;
    logic [3:0]  k;
    if (held_n < SLOTS_DEF) begin
      held_slots[held_n] = s;
      held_n++;
    end
    if (!last) return;
    key_lo = 0;
    key_hi = 0;
    if (mode_shadow == MODE_BY_TYPE) begin
      key_lo = TYPE_FIRST_KEY;
      key_hi = TYPE_COUNT_DEF;
    end else if (mode_shadow == MODE_BY_GRADE) begin
      key_hi = GRADE_COUNT_DEF;
    end
    pos = 0;
    for (int unsigned key = key_lo; key < key_hi; key++) begin
      for (int unsigned i = 0; i < held_n; i++) begin
        k = (mode_shadow == MODE_BY_GRADE) ? held_slots[i].grade_key : held_slots[i].type_key;
        if (held_slots[i].occupied && held_slots[i].has_data && k == key) begin
          pending_sorted.push_back('{1'b1, held_slots[i].payload, pos[5:0], pos == held_n - 1});
          pos++;
        end
      end
    end
    while (pos < held_n) begin
      pending_sorted.push_back('{1'b0, 32'h0, pos[5:0], pos == held_n - 1});
      pos++;
    end
    held_n = 0;
  endtask

  task automatic send_slot(input slot_t s, input bit last);
    int gap;
    bit taken;
    gap = 0;
    if (!no_gaps) while ($urandom_range(0, 99) < 26) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, s};
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Hold the sender until every expected result is out and the core is idle.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= m;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    mode_shadow = m;
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk_i) begin
    sorted_slot_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sorted.size() == 0) begin
        $error("result with nothing expected: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_sorted.pop_front();
        check_field("out_occupied", 32'(want.occupied), 32'(m_axis_tdata[0]));
        check_field("out_payload", want.payload, m_axis_tdata[32:1]);
        check_field("out_index", 32'(want.index), 32'(m_axis_tdata[38:33]));
        check_field("out_last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    slot_t       s;
    int unsigned sent;
    int unsigned len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].wr) write_mode(plan[r].mode);
      s = '{plan[r].pay, plan[r].gr, plan[r].ty, plan[r].data, plan[r].occ};
      send_slot(s, plan[r].last);
      // typed rows are single-slot lists: one result at index zero
      if (plan[r].typed) pending_sorted.push_back('{plan[r].exp_occ, plan[r].exp_pay, 6'd0, 1'b1});
      else bucket_sort_slot(s, plan[r].last);
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_mode(phase_mode[ph]);
      no_gaps <= (ph == 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // first list of phase 0 overflows the store, of phase 1 fills it; then mostly short lists
        if (sent == 0 && ph == 0) len = 35;
        else if (sent == 0 && ph == 1) len = 32;
        else if ($urandom_range(0, 11) == 0) len = $urandom_range(30, 36);
        else len = $urandom_range(1, 8);
        for (int unsigned j = 0; j < len; j++) begin
          s.occupied  = $urandom_range(0, 9) != 0;
          s.has_data  = $urandom_range(0, 9) != 0;
          s.type_key  = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 7));
          s.grade_key = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 7));
          s.payload   = $urandom;
          send_slot(s, j == len - 1);
          bucket_sort_slot(s, j == len - 1);
        end
        sent += len;
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/sbsk_pkg.sv
hw/rtl/sbsk_ram.sv
hw/rtl/stable_bucket_sort_by_key_core.sv
verif/stable_bucket_sort_by_key_core_tb.sv
